>>> hw/rtl/ebj_pkg.sv
// shared types, codes and constants of the exponential backoff deadline generator
// depends on nothing; used by the interfaces, controller, datapath and top level
package ebj_pkg;

    // deadline saturation range, bits of time
    localparam int TIME_WIDTH = 48;
    localparam logic [63:0] DL_CAP = (TIME_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                        : ((64'd1 << TIME_WIDTH) - 64'd1);

    localparam int KIND_W   = 2;
    localparam int NOW_W    = 47;
    localparam int DL_W     = 48;
    localparam int CUR_W    = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STEP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROWTH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIMEOUT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED     = 3'd5;

    // register reset values
    localparam logic [31:0] INIT_RST   = 32'd1000;
    localparam logic [15:0] GROWTH_RST = 16'd410;
    localparam logic [15:0] JITTER_RST = 16'd13107;
    localparam logic [31:0] MIN_RST    = 32'd20000;
    localparam logic [31:0] MAX_RST    = 32'd120000;
    localparam logic [31:0] SEED_RST   = 32'd1;

    // 31-bit generator
    localparam logic [30:0] LCG_MUL    = 31'h41C6_4E6D;
    localparam logic [30:0] LCG_ADD    = 31'd12345;
    localparam logic [30:0] HALF_RANGE = 31'h4000_0000;

    // saturation limits of the stored timeout, at the width of the jitter sum
    localparam logic signed [59:0] CUR_MAX = 60'sh000_7FFF_FFFF_FFFF;
    localparam logic signed [59:0] CUR_MIN = 60'shFFF_8000_0000_0000;

    // jitter multiply: grown magnitude taken sixteen bits a pass
    localparam int CHUNK_W = 2;
    localparam logic [CHUNK_W-1:0] CHUNK_LAST = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GROW,
        S_PREP,
        S_MUL,
        S_ACC,
        S_SUM,
        S_SAT,
        S_EMIT
    } t_ebj_state;

    typedef struct packed {
        logic               capture;
        logic               ld_init;
        logic               grow;
        logic               prep;
        logic               mul;
        logic               acc;
        logic               last;
        logic               sum;
        logic               sat;
        logic               emit;
        logic [CHUNK_W-1:0] chunk;
    } t_ebj_cmd;

endpackage

>>> hw/rtl/ebj_in_if.sv
// input channel of the deadline generator: event kind and current time
// depends on ebj_pkg
interface ebj_in_if;
    logic                         valid;
    logic                         ready;
    logic [ebj_pkg::KIND_W-1:0]   kind;
    logic [ebj_pkg::NOW_W-1:0]    now_ms;

    modport source (output valid, kind, now_ms, input ready);
    modport sink   (input valid, kind, now_ms, output ready);
endinterface

>>> hw/rtl/ebj_out_if.sv
// result channel of the deadline generator: deadline and applied timeout
// depends on ebj_pkg
interface ebj_out_if;
    logic                         valid;
    logic                         ready;
    logic [ebj_pkg::DL_W-1:0]     deadline_ms;
    logic [ebj_pkg::NOW_W-1:0]    applied_timeout_ms;

    modport source (output valid, deadline_ms, applied_timeout_ms, input ready);
    modport sink   (input valid, deadline_ms, applied_timeout_ms, output ready);
endinterface

>>> hw/rtl/ebj_ctrl.sv
// controller of the deadline generator: event decode, step sequencing, result valid
// depends on ebj_pkg; drives the command struct of ebj_dpath
module ebj_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [ebj_pkg::KIND_W-1:0]  i_kind,
    output logic                        o_in_ready,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output ebj_pkg::t_ebj_cmd           o_cmd
);

    ebj_pkg::t_ebj_state r_state, n_state;
    logic [ebj_pkg::CHUNK_W-1:0] r_chunk, n_chunk;
    logic r_out_valid, n_out_valid;
    logic w_in_xfer;

    assign o_in_ready  = (r_state == ebj_pkg::S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ebj_pkg::S_IDLE;
            r_chunk     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chunk     <= n_chunk;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_chunk = r_chunk;
        o_cmd   = '0;
        o_cmd.chunk = r_chunk;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ebj_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    o_cmd.capture = 1'b1;
                    case (i_kind)
                        ebj_pkg::KIND_BEGIN: begin
                            o_cmd.ld_init = 1'b1;
                            n_state = ebj_pkg::S_EMIT;
                        end
                        ebj_pkg::KIND_STEP: begin
                            n_state = ebj_pkg::S_GROW;
                        end
                        ebj_pkg::KIND_RESET: begin
                            o_cmd.ld_init = 1'b1;
                        end
                        default: begin
                            // unused kind: dropped
                        end
                    endcase
                end
            end
            ebj_pkg::S_GROW: begin
                o_cmd.grow = 1'b1;
                n_state = ebj_pkg::S_PREP;
            end
            ebj_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                n_chunk = '0;
                n_state = ebj_pkg::S_MUL;
            end
            ebj_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ebj_pkg::S_ACC;
            end
            ebj_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_chunk == ebj_pkg::CHUNK_LAST) begin
                    o_cmd.last = 1'b1;
                    n_chunk = '0;
                    n_state = ebj_pkg::S_SUM;
                end else begin
                    n_chunk = r_chunk + 1'b1;
                    n_state = ebj_pkg::S_MUL;
                end
            end
            ebj_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = ebj_pkg::S_SAT;
            end
            ebj_pkg::S_SAT: begin
                o_cmd.sat = 1'b1;
                n_state = ebj_pkg::S_EMIT;
            end
            ebj_pkg::S_EMIT: begin
                // hold here until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ebj_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ebj_pkg::S_IDLE;
            end
        endcase
    end

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ebj_pkg::S_EMIT))
        else $error("result valid raised outside the emit state");

    a_last_pass_to_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ebj_pkg::S_ACC && r_chunk == ebj_pkg::CHUNK_LAST)
        |=> (r_state == ebj_pkg::S_SUM))
        else $error("jitter accumulate did not end after the last pass");

    a_step_starts_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_kind == ebj_pkg::KIND_STEP) |=> (r_state == ebj_pkg::S_GROW))
        else $error("step transfer did not start the growth sequence");

endmodule

>>> hw/rtl/ebj_dpath.sv
// datapath of the deadline generator: registers, timeout state, generator,
// growth and jitter arithmetic, result register; depends on ebj_pkg
module ebj_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ebj_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ebj_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  ebj_pkg::t_ebj_cmd               i_cmd,
    input  logic [ebj_pkg::NOW_W-1:0]       i_now_ms,
    output logic [ebj_pkg::DL_W-1:0]        o_deadline_ms,
    output logic [ebj_pkg::NOW_W-1:0]       o_applied_timeout_ms
);

    // configuration
    logic [31:0] r_init, r_min, r_max;
    logic [15:0] r_gf, r_jf;

    // state
    logic signed [ebj_pkg::CUR_W-1:0] r_cur;
    logic [30:0] r_rng;

    // working registers
    logic [ebj_pkg::NOW_W-1:0] r_now;
    logic [63:0]        r_gm;
    logic               r_gneg;
    logic signed [56:0] r_c;
    logic [45:0]        r_aj;
    logic               r_neg;
    logic [61:0]        r_pp;
    logic [63:0]        r_acc;
    logic               r_sticky;
    logic signed [59:0] r_s;
    logic               r_rem;
    logic [ebj_pkg::DL_W-1:0]  r_dl;
    logic [ebj_pkg::NOW_W-1:0] r_app;

    logic [ebj_pkg::CUR_W-1:0] w_cur_mag;
    logic [30:0]        w_lcg;
    logic [30:0]        w_a;
    logic [55:0]        w_tmag;
    logic signed [56:0] w_t, w_max57;
    logic [15:0]        w_chunk;
    logic [63:0]        w_acc_sum;
    logic signed [59:0] w_c_ext, w_m_ext, w_s_adj;
    logic [ebj_pkg::CUR_W-1:0] w_s_sat;
    logic signed [ebj_pkg::CUR_W-1:0] w_min48, w_app;
    logic [ebj_pkg::DL_W-1:0] w_dl_sum, w_dl;

    assign w_cur_mag = r_cur[ebj_pkg::CUR_W-1] ? ebj_pkg::CUR_W'(-r_cur) : r_cur;
    assign w_lcg     = r_rng * ebj_pkg::LCG_MUL + ebj_pkg::LCG_ADD;

    // distance of the generator value from mid range
    assign w_a = r_rng[30] ? {1'b0, r_rng[29:0]} : (ebj_pkg::HALF_RANGE - r_rng);

    // truncation toward zero of the grown value, then the ceiling
    assign w_tmag  = r_gm[63:8];
    assign w_t     = r_gneg ? -$signed({1'b0, w_tmag}) : $signed({1'b0, w_tmag});
    assign w_max57 = $signed({25'd0, r_max});

    assign w_chunk   = r_gm[{i_cmd.chunk, 4'b0000} +: 16];
    assign w_acc_sum = r_acc + {2'b00, r_pp};

    assign w_c_ext = {{3{r_c[56]}}, r_c};
    assign w_m_ext = {2'b00, r_acc[63:6]};

    // pull the sum toward zero when the dropped jitter fraction is nonzero, then saturate
    always_comb begin
        w_s_adj = r_s;
        if (!r_neg && r_s < 60'sd0 && r_rem) begin
            w_s_adj = r_s + 60'sd1;
        end else if (r_neg && r_s > 60'sd0 && r_rem) begin
            w_s_adj = r_s - 60'sd1;
        end
        if (w_s_adj > ebj_pkg::CUR_MAX) begin
            w_s_sat = ebj_pkg::CUR_MAX[ebj_pkg::CUR_W-1:0];
        end else if (w_s_adj < ebj_pkg::CUR_MIN) begin
            w_s_sat = ebj_pkg::CUR_MIN[ebj_pkg::CUR_W-1:0];
        end else begin
            w_s_sat = w_s_adj[ebj_pkg::CUR_W-1:0];
        end
    end

    assign w_min48  = $signed({16'd0, r_min});
    assign w_app    = (r_cur > w_min48) ? r_cur : w_min48;
    assign w_dl_sum = {1'b0, r_now} + {1'b0, w_app[ebj_pkg::NOW_W-1:0]};
    assign w_dl     = ({16'd0, w_dl_sum} > ebj_pkg::DL_CAP) ? ebj_pkg::DL_CAP[ebj_pkg::DL_W-1:0]
                                                            : w_dl_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= ebj_pkg::INIT_RST;
            r_gf   <= ebj_pkg::GROWTH_RST;
            r_jf   <= ebj_pkg::JITTER_RST;
            r_min  <= ebj_pkg::MIN_RST;
            r_max  <= ebj_pkg::MAX_RST;
            r_cur  <= $signed({16'd0, ebj_pkg::INIT_RST});
            r_rng  <= ebj_pkg::SEED_RST[30:0];
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ebj_pkg::CFG_INIT_TIMEOUT: r_init <= i_cfg_data;
                    ebj_pkg::CFG_GROWTH:       r_gf   <= i_cfg_data[15:0];
                    ebj_pkg::CFG_JITTER:       r_jf   <= i_cfg_data[15:0];
                    ebj_pkg::CFG_MIN_TIMEOUT:  r_min  <= i_cfg_data;
                    ebj_pkg::CFG_MAX_TIMEOUT:  r_max  <= i_cfg_data;
                    ebj_pkg::CFG_RNG_SEED:     r_rng  <= i_cfg_data[30:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.grow) begin
                r_rng <= w_lcg;
            end
            if (i_cmd.ld_init) begin
                r_cur <= $signed({16'd0, r_init});
            end else if (i_cmd.sat) begin
                r_cur <= $signed(w_s_sat);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now <= i_now_ms;
        end
        if (i_cmd.grow) begin
            r_gm   <= w_cur_mag * r_gf;
            r_gneg <= r_cur[ebj_pkg::CUR_W-1];
        end
        if (i_cmd.prep) begin
            r_c      <= (w_t < w_max57) ? w_t : w_max57;
            r_aj     <= w_a * r_jf;
            r_neg    <= (!r_rng[30]) ^ r_gneg;
            r_acc    <= '0;
            r_sticky <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_pp <= r_aj * w_chunk;
        end
        if (i_cmd.acc) begin
            if (i_cmd.last) begin
                r_acc <= w_acc_sum;
            end else begin
                r_acc    <= {16'd0, w_acc_sum[63:16]};
                r_sticky <= r_sticky | (|w_acc_sum[15:0]);
            end
        end
        if (i_cmd.sum) begin
            r_s   <= r_neg ? (w_c_ext - w_m_ext) : (w_c_ext + w_m_ext);
            r_rem <= r_sticky | (|r_acc[5:0]);
        end
        if (i_cmd.emit) begin
            r_dl  <= w_dl;
            r_app <= w_app[ebj_pkg::NOW_W-1:0];
        end
    end

    assign o_deadline_ms        = r_dl;
    assign o_applied_timeout_ms = r_app;

    a_init_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_init |=> (r_cur == $signed({16'd0, $past(r_init)})))
        else $error("timeout not reloaded from the initial register");

    a_ceiling_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.prep |=> (r_c <= $signed({25'd0, $past(r_max)})))
        else $error("grown timeout above the ceiling");

    a_grown_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.grow |=> (r_gm[63] == 1'b0))
        else $error("grown magnitude overflowed");

endmodule

>>> hw/rtl/exponential_backoff_with_jitter.sv
// Retry-deadline generator with exponential backoff and generator-driven jitter.
// A begin event answers from the emit state after its transfer, a reset event
// answers nothing, and a step event answers after this run of states: grow
// grows the timeout and advances the generator, prep clamps it, multiply and
// accumulate run the jitter product as four sixteen-bit partial products of the
// grown magnitude (a multiply state and an accumulate state each), and sum
// and saturate add, round and saturate before the result is loaded. It sits in
// an output register; the next event is taken once the controller is idle again,
// and a finished event waits in the emit state while an earlier result is still
// untaken. Configuration writes take effect at once; a seed write reloads the
// generator. No clearing pass follows reset.
module exponential_backoff_with_jitter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ebj_in_if.sink                          i_in,
    ebj_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [ebj_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ebj_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ebj_pkg::t_ebj_cmd w_cmd;
    logic w_in_ready;
    logic w_out_valid;

    ebj_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_kind      (i_in.kind),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    ebj_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_cmd                (w_cmd),
        .i_now_ms             (i_in.now_ms),
        .o_deadline_ms        (o_out.deadline_ms),
        .o_applied_timeout_ms (o_out.applied_timeout_ms)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule

>>> verif/ebj_backoff_tracker_pkg.sv
`timescale 1ns / 100ps
// backoff tracker: predicts the deadline generator and keeps the deadlines still due
// depends on ebj_pkg
package ebj_backoff_tracker_pkg;
    import ebj_pkg::*;

    typedef struct packed {
        logic [DL_W-1:0]  deadline_ms;
        logic [NOW_W-1:0] applied_ms;
    } t_due_deadline;

    class backoff_tracker;
        logic [31:0]             init_timeout;
        logic [15:0]             growth;
        logic [15:0]             jitter;
        logic [31:0]             min_timeout;
        logic [31:0]             max_timeout;
        logic signed [CUR_W-1:0] timeout;
        logic [30:0]             rng;
        t_due_deadline           due_q[$];
        int unsigned             mismatches;

        function new();
            init_timeout = INIT_RST;
            growth       = GROWTH_RST;
            jitter       = JITTER_RST;
            min_timeout  = MIN_RST;
            max_timeout  = MAX_RST;
            rng          = SEED_RST[30:0];
            timeout      = {16'd0, INIT_RST};
            mismatches   = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INIT_TIMEOUT: init_timeout = data;
                CFG_GROWTH:       growth       = data[15:0];
                CFG_JITTER:       jitter       = data[15:0];
                CFG_MIN_TIMEOUT:  min_timeout  = data;
                CFG_MAX_TIMEOUT:  max_timeout  = data;
                // only the low 31 bits ever reach the generator output
                CFG_RNG_SEED:     rng          = data[30:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void grow_timeout();
            longint       cur, gf, grown, whole, ceiling, mag, total;
            logic [30:0]  spread;
            logic [63:0]  grown_abs;
            logic [127:0] wide;
            bit           negative, frac;
            cur     = timeout;
            gf      = growth;
            grown   = cur * gf;
            whole   = grown / 256;
            ceiling = max_timeout;
            if (whole > ceiling) whole = ceiling;
            rng       = LCG_MUL * rng + LCG_ADD;
            spread    = (rng >= HALF_RANGE) ? rng - HALF_RANGE : HALF_RANGE - rng;
            grown_abs = (grown < 0) ? -grown : grown;
            negative  = (rng < HALF_RANGE) != (grown < 0);
            // exact jitter magnitude: spread/2^30 * jitter/2^16 * grown/2^8
            wide = spread;
            wide = wide * jitter;
            wide = wide * grown_abs;
            mag  = wide[117:54];
            frac = |wide[53:0];
            if (spread == 0 || jitter == 0 || grown_abs == 0) negative = 1'b0;
            // truncate toward zero of the exact sum
            if (!negative) begin
                total = whole + mag;
                if (total < 0 && frac) total = total + 1;
            end else begin
                total = whole - mag;
                if (total > 0 && frac) total = total - 1;
            end
            if (total > CUR_MAX) total = CUR_MAX;
            else if (total < CUR_MIN) total = CUR_MIN;
            timeout = total[CUR_W-1:0];
        endfunction

        function void queue_deadline(logic [NOW_W-1:0] now);
            longint        cur, floor_ms, app;
            logic [63:0]   cap, sum;
            t_due_deadline due;
            cur      = timeout;
            floor_ms = min_timeout;
            app      = (cur > floor_ms) ? cur : floor_ms;
            due.applied_ms = app[NOW_W-1:0];
            cap = DL_CAP;
            sum = (now > cap - due.applied_ms) ? cap : now + due.applied_ms;
            due.deadline_ms = sum[DL_W-1:0];
            due_q.push_back(due);
        endfunction

        function void note_event(logic [KIND_W-1:0] kind, logic [NOW_W-1:0] now);
            case (kind)
                KIND_BEGIN: begin
                    timeout = {16'd0, init_timeout};
                    queue_deadline(now);
                end
                KIND_STEP: begin
                    grow_timeout();
                    queue_deadline(now);
                end
                KIND_RESET: timeout = {16'd0, init_timeout};
                default: ;
            endcase
        endfunction

        function void check_deadline(logic [DL_W-1:0] dl, logic [NOW_W-1:0] app);
            t_due_deadline want;
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: deadline %0d applied %0d", dl, app);
                return;
            end
            want = due_q.pop_front();
            if (dl !== want.deadline_ms || app !== want.applied_ms) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: deadline want %0d got %0d, applied want %0d got %0d",
                             want.deadline_ms, dl, want.applied_ms, app);
            end
        endfunction
    endclass

endpackage

>>> verif/testbench.sv
`timescale 1ns / 100ps
// top of the deadline generator bench: drives events and register writes, checks results
// depends on ebj_pkg, ebj_in_if, ebj_out_if, ebj_backoff_tracker_pkg and the block itself
module testbench;
    import ebj_pkg::*;
    import ebj_backoff_tracker_pkg::*;

    localparam logic [KIND_W-1:0]    KIND_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 3'd6;
    localparam logic [NOW_W-1:0]     NOW_MAX       = '1;
    localparam int                   LIMIT_CYCLES  = 600000;
    localparam int                   SETTLE_CYCLES = 20;
    localparam int                   DRAIN_CYCLES  = 30;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = CFG_INIT_TIMEOUT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    bit                    sender_gaps     = 1'b1;
    bit                    receiver_stalls = 1'b1;
    int                    cycle_count     = 0;
    backoff_tracker        tracker;

    ebj_in_if  event_ch ();
    ebj_out_if deadline_ch ();

    exponential_backoff_with_jitter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (event_ch),
        .o_out      (deadline_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [KIND_W-1:0] pick_kind();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 12) return KIND_BEGIN;
        if (roll < 90) return KIND_STEP;
        if (roll < 96) return KIND_RESET;
        return KIND_UNUSED;
    endfunction

    function automatic logic [NOW_W-1:0] pick_now();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return '0;
            1: return NOW_MAX;
            default: return raw[NOW_W-1:0];
        endcase
    endfunction

    function automatic logic [31:0] pick_wide_reg();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 2000);
            3: return $urandom_range(1000, 300000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_narrow_reg();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'h0000_FFFF;
            2: return $urandom_range(200, 700);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // valid stays high across back-to-back transfers, dropped only for a gap
    task automatic send_event(input logic [KIND_W-1:0] kind, input logic [NOW_W-1:0] now);
        @(negedge i_clk);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            event_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        event_ch.valid  <= 1'b1;
        event_ch.kind   <= kind;
        event_ch.now_ms <= now;
        do @(posedge i_clk); while (!event_ch.ready);
        tracker.note_event(kind, now);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        event_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // resets and ignored kinds leave nothing to wait for, so give them time to finish
    task automatic settle_block();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.apply_reg(idx, data);
    endtask

    task automatic load_random_setting();
        settle_block();
        set_reg(CFG_INIT_TIMEOUT, pick_wide_reg());
        set_reg(CFG_GROWTH, pick_narrow_reg());
        set_reg(CFG_JITTER, pick_narrow_reg());
        set_reg(CFG_MIN_TIMEOUT, pick_wide_reg());
        set_reg(CFG_MAX_TIMEOUT, pick_wide_reg());
        set_reg(CFG_RNG_SEED, $urandom);
    endtask

    task automatic run_random_events(input int count);
        for (int n = 0; n < count; n++) begin
            // now and then hold off until the block has answered everything
            if ($urandom_range(0, 99) == 0) wait_results_drained();
            send_event(pick_kind(), pick_now());
        end
    endtask

    initial begin
        deadline_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (receiver_stalls && $urandom_range(0, 5) == 0) begin
                deadline_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            deadline_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end else if (i_rst_n && deadline_ch.valid && deadline_ch.ready) begin
            tracker.check_deadline(deadline_ch.deadline_ms, deadline_ch.applied_timeout_ms);
        end
    end

    initial begin
        tracker = new();
        event_ch.valid  = 1'b0;
        event_ch.kind   = KIND_BEGIN;
        event_ch.now_ms = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: plain growth, reload, ignored kind with both bits set
        send_event(KIND_BEGIN, '0);
        send_event(KIND_STEP, NOW_MAX);
        send_event(KIND_STEP, 47'd12345);
        send_event(KIND_STEP, '0);
        send_event(KIND_RESET, NOW_MAX);
        send_event(KIND_UNUSED, NOW_MAX);
        send_event(KIND_STEP, 47'h2AAA_AAAA_AAAA);

        // full growth and jitter under the highest ceiling drive the timeout negative
        settle_block();
        set_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        set_reg(CFG_GROWTH, 32'h0000_FFFF);
        set_reg(CFG_JITTER, 32'h0000_FFFF);
        set_reg(CFG_MAX_TIMEOUT, 32'hFFFF_FFFF);
        set_reg(CFG_INIT_TIMEOUT, 32'hFFFF_FFFF);
        set_reg(CFG_MIN_TIMEOUT, 32'd0);
        set_reg(CFG_RNG_SEED, 32'hFFFF_FFFF);
        send_event(KIND_BEGIN, NOW_MAX);
        repeat (5) send_event(KIND_STEP, NOW_MAX);

        // zero ceiling leaves only the jitter, so the timeout goes negative
        settle_block();
        set_reg(CFG_MAX_TIMEOUT, 32'd0);
        set_reg(CFG_GROWTH, 32'd512);
        set_reg(CFG_INIT_TIMEOUT, 32'd5000);
        set_reg(CFG_RNG_SEED, 32'd0);
        send_event(KIND_BEGIN, 47'd1);
        repeat (6) send_event(KIND_STEP, pick_now());

        // largest minimum props up the applied timeout
        settle_block();
        set_reg(CFG_MIN_TIMEOUT, 32'hFFFF_FFFF);
        send_event(KIND_STEP, NOW_MAX);

        // no growth, no jitter, zero start
        settle_block();
        set_reg(CFG_GROWTH, 32'd0);
        set_reg(CFG_JITTER, 32'd0);
        set_reg(CFG_INIT_TIMEOUT, 32'd0);
        set_reg(CFG_MIN_TIMEOUT, 32'd0);
        send_event(KIND_BEGIN, pick_now());
        send_event(KIND_STEP, pick_now());

        for (int p = 0; p < 11; p++) begin
            if (p == 10) begin
                sender_gaps     = 1'b0;
                receiver_stalls = 1'b0;
            end
            load_random_setting();
            run_random_events(110);
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ebj_pkg.sv
hw/rtl/ebj_in_if.sv
hw/rtl/ebj_out_if.sv
hw/rtl/ebj_ctrl.sv
hw/rtl/ebj_dpath.sv
hw/rtl/exponential_backoff_with_jitter.sv
verif/ebj_backoff_tracker_pkg.sv
verif/testbench.sv
